// ===== src/glottal_pulse_oscillator_assert.svh =====
// ----------------------------------------------------------------------------
// Glottal pulse oscillator assertion macros
// Shared property forms for the concurrent checks of the oscillator.
// ----------------------------------------------------------------------------
`ifndef GLOTTAL_PULSE_OSCILLATOR_ASSERT_SVH
`define GLOTTAL_PULSE_OSCILLATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GPO_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glottal pulse oscillator check failed");

// Consequent must hold in the cycle after the antecedent.
`define GPO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glottal pulse oscillator check failed");

`endif

// ===== src/gpo_pkg.sv =====
// ----------------------------------------------------------------------------
// Glottal pulse oscillator package
// Shared constants, opcodes, controller/datapath structs and the cosine entry.
// ----------------------------------------------------------------------------
package gpo_pkg;

    localparam int GPO_PHASE_BITS     = 32;
    localparam int GPO_COS_TABLE_BITS = 10;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic [CFG_AW-1:0] CFG_PHASE_STEP      = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_OPEN_QUOTIENT   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_SPEED_QUOTIENT  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_FREQUENCY_SCALE = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_JITTER_DEPTH    = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_SHIMMER_DEPTH   = 3'd5;

    localparam int IN_W  = 32;
    localparam int OUT_W = 40;

    // Shared divider geometry
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 17;
    localparam int DIV_CW = 6;
    localparam logic [DIV_CW-1:0] DIV_BITS_SHAPE = 6'd33;
    localparam logic [DIV_CW-1:0] DIV_BITS_PHASE = 6'd33;
    localparam logic [DIV_CW-1:0] DIV_BITS_OPEN  = 6'd29;
    localparam logic [DIV_CW-1:0] DIV_BITS_INC   = 6'd48;

    typedef logic [4:0] t_op;
    localparam t_op OP_NONE      = 5'd0;
    localparam t_op OP_LOAD_IN   = 5'd1;
    localparam t_op OP_MUL_SHAPE = 5'd2;
    localparam t_op OP_DIV_RISE  = 5'd3;
    localparam t_op OP_SET_RISE  = 5'd4;
    localparam t_op OP_MUL_MEAN  = 5'd5;
    localparam t_op OP_SET_MEAN  = 5'd6;
    localparam t_op OP_DIV_PHASE = 5'd7;
    localparam t_op OP_SET_IDX   = 5'd8;
    localparam t_op OP_READ_COS  = 5'd9;
    localparam t_op OP_SET_OPEN  = 5'd10;
    localparam t_op OP_DIV_OPEN  = 5'd11;
    localparam t_op OP_MUL_A     = 5'd12;
    localparam t_op OP_MUL_B     = 5'd13;
    localparam t_op OP_MUL_C     = 5'd14;
    localparam t_op OP_SET_FLOW  = 5'd15;
    localparam t_op OP_DIV_INC   = 5'd16;
    localparam t_op OP_ADV_PHASE = 5'd17;
    localparam t_op OP_MUL_JIT   = 5'd18;
    localparam t_op OP_MUL_SHIM  = 5'd19;
    localparam t_op OP_SET_SHIM  = 5'd20;
    localparam t_op OP_OUT_LOAD  = 5'd21;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic wrap_now;
    } t_status;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] COS_DIVS [1:7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                               64'd90, 64'd132, 64'd182};

    // Quarter-wave cosine entry in Q1.15, Taylor series to x^14 in Q2.30.
    // Evaluated on constant arguments only, to fill the cosine ROM.
    function automatic logic [15:0] qcos_entry(input int unsigned idx, input int unsigned cb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        longint      s;
        x  = (64'(idx) * HALF_PI_Q30 + ((64'd1 << cb) >> 1)) >> cb;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        t  = 64'd1 << 30;
        s  = longint'(t);
        for (int k = 1; k <= 7; k++) begin
            t = ((t * x2) >> 30) / COS_DIVS[k];
            if ((k % 2) == 1) begin
                s = s - longint'(t);
            end else begin
                s = s + longint'(t);
            end
        end
        if (s < 0) begin
            s = 0;
        end
        if (s > (longint'(1) << 30)) begin
            s = longint'(1) << 30;
        end
        return 16'((64'(s) + (64'd1 << 14)) >> 15);
    endfunction

endpackage

// ===== src/glottal_pulse_oscillator.sv =====
// ----------------------------------------------------------------------------
// Glottal pulse oscillator
// Rosenberg glottal flow generator, one flow sample per input item.
// ----------------------------------------------------------------------------
// Each accepted item yields one result: the flow sample, the fold openness and
// a flag for the start of a new pitch period. The period is a raised-cosine
// rise, a quarter-cosine fall and a closed phase; rise and fall lengths and the
// mean flow are re-derived from the quotients at the start of every item, so a
// configuration write takes effect on the next item. The deviations carried by
// the item are used only when that item wraps the phase. One item is in work at
// a time; ready returns only when its result has entered the output register,
// which waits for the previous result to leave it. The work is carried by
// the shared restoring divider, which produces one quotient bit per cycle for
// four divisions per item, and by the sequencer steps around them. A finished
// result waits in the output register, and the next item is accepted while it
// is held there.
// ----------------------------------------------------------------------------
`include "glottal_pulse_oscillator_assert.svh"

module glottal_pulse_oscillator #(
    parameter int PHASE_BITS     = gpo_pkg::GPO_PHASE_BITS,
    parameter int COS_TABLE_BITS = gpo_pkg::GPO_COS_TABLE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port
    input  logic                        i_cfg_we,
    input  logic [gpo_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [gpo_pkg::CFG_DW-1:0]  i_cfg_wdata,
    // Input item stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [15:0] period_deviation, [31:16] level_deviation
    input  logic [gpo_pkg::IN_W-1:0]    s_axis_tdata,
    // Result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [19:0] flow_sample, [35:20] fold_openness, [36] period_wrapped, [39:37] zero
    output logic [gpo_pkg::OUT_W-1:0]   m_axis_tdata
);
    import gpo_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer: owns the handshakes; one op per cycle, pausing for I/O and divider
    gpo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Datapath: registers, shared multiplier, divider and cosine ROM
    gpo_datapath #(
        .PHASE_BITS     (PHASE_BITS),
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .o_out_data  (m_axis_tdata)
    );

    // Only one item in work: ready drops right after acceptance
    `GPO_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // Loading the output register always presents a result
    `GPO_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_cmd.op == OP_OUT_LOAD, m_axis_tvalid)
    // The divider is never left running while waiting for a new item
    `GPO_ASSERT_NOW(a_div_idle, i_clk, i_rst_n, w_status.div_busy, !s_axis_tready)

endmodule

// ===== src/gpo_div.sv =====
// ----------------------------------------------------------------------------
// Glottal pulse oscillator divider
// Restoring unsigned divider, one quotient bit per cycle, variable length.
// ----------------------------------------------------------------------------
module gpo_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gpo_pkg::DIV_CW-1:0]  i_nbits,
    input  logic [gpo_pkg::DIV_NW-1:0]  i_num,
    input  logic [gpo_pkg::DIV_DW-1:0]  i_den,
    output logic                        o_busy,
    output logic [gpo_pkg::DIV_NW-1:0]  o_quot
);
    import gpo_pkg::*;

    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_quot;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   w_trial;
    logic [DIV_DW:0]   w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_quot[DIV_NW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};
    assign o_busy  = (r_cnt != '0);
    assign o_quot  = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_nbits;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Align the numerator to the top so only its significant bits are walked.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num << (DIV_CW'(DIV_NW) - i_nbits);
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_cnt != '0) begin
            r_rem  <= w_ge ? w_diff[DIV_DW-1:0] : w_trial[DIV_DW-1:0];
            r_quot <= {r_quot[DIV_NW-2:0], w_ge};
        end
    end

endmodule

// ===== src/gpo_datapath.sv =====
// ----------------------------------------------------------------------------
// Glottal pulse oscillator datapath
// Configuration, state, shared multiplier, divider, cosine ROM and output.
// ----------------------------------------------------------------------------
module gpo_datapath #(
    parameter int PHASE_BITS     = gpo_pkg::GPO_PHASE_BITS,
    parameter int COS_TABLE_BITS = gpo_pkg::GPO_COS_TABLE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gpo_pkg::t_cmd               i_cmd,
    output gpo_pkg::t_status            o_status,
    input  logic                        i_cfg_we,
    input  logic [gpo_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [gpo_pkg::CFG_DW-1:0]  i_cfg_wdata,
    input  logic [gpo_pkg::IN_W-1:0]    i_in_data,
    output logic [gpo_pkg::OUT_W-1:0]   o_out_data
);
    import gpo_pkg::*;

    localparam int PH_DOWN = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
    localparam int PH_UP   = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
    localparam int IW      = 34 + PH_DOWN;
    localparam int COS_N   = (1 << COS_TABLE_BITS) + 1;
    localparam int CB      = COS_TABLE_BITS;

    localparam logic [1:0] RGN_RISE   = 2'd0;
    localparam logic [1:0] RGN_FALL   = 2'd1;
    localparam logic [1:0] RGN_CLOSED = 2'd2;

    // Configuration
    logic [31:0] r_phase_step;
    logic [15:0] r_oq, r_sq, r_fs, r_jd, r_sd;
    logic [15:0] w_oq, w_sq, w_fs, w_jd, w_sd;
    logic [16:0] w_den_shape;

    // State and working registers
    logic [PHASE_BITS-1:0] r_acc;
    logic [16:0] r_ps, r_amp;
    logic [15:0] r_rl, r_fl, r_mf;
    logic [15:0] r_pdev, r_ldev;
    logic [1:0]  r_region;
    logic        r_fold;
    logic [CB:0] r_idx;
    logic [15:0] r_cos;
    logic [16:0] r_open;
    logic [15:0] r_openness;
    logic [19:0] r_flow;
    logic        r_wrap;
    logic [33:0] r_prod;
    logic [OUT_W-1:0] r_out;

    // Divider hookup
    logic              w_div_start;
    logic [DIV_CW-1:0] w_div_nbits;
    logic [DIV_NW-1:0] w_div_num;
    logic [DIV_DW-1:0] w_div_den;
    logic              w_div_busy;
    logic [DIV_NW-1:0] w_quot;

    // Combinational helpers
    logic [PHASE_BITS+31:0] w_ph_wide;
    logic [31:0] w_ph32;
    logic        w_in_rise, w_in_fall;
    logic [32:0] w_fall_end;
    logic [15:0] w_rise_q, w_fl_n;
    logic [33:0] w_mean_sum;
    logic [16:0] w_u, w_f;
    logic [17:0] w_mirror;
    logic [CB+16:0] w_idx_full;
    logic [16:0] w_ma, w_mb;
    logic [34:0] w_rnd16, w_rnd14;
    logic [16:0] w_a17;
    logic [20:0] w_c;
    logic [31:0] w_rnd_dev;
    logic [16:0] w_dev_mag;
    logic [16:0] w_pabs, w_labs;
    logic [16:0] w_ps_c;
    logic [IW-1:0] w_inc;
    logic [IW:0]   w_sum;
    logic          w_wrap;
    logic [15:0]   w_cos_rom [0:COS_N-1];

    always_comb begin
        w_oq = (r_oq < 16'd16384) ? 16'd16384 : ((r_oq > 16'd55706) ? 16'd55706 : r_oq);
        w_sq = (r_sq < 16'd256) ? 16'd256 : r_sq;
        w_fs = (r_fs < 16'd2048) ? 16'd2048 : ((r_fs > 16'd32768) ? 16'd32768 : r_fs);
        w_jd = (r_jd > 16'd32768) ? 16'd32768 : r_jd;
        w_sd = (r_sd > 16'd58982) ? 16'd58982 : r_sd;
    end
    assign w_den_shape = 17'd256 + {1'b0, w_sq};

    // Phase as Q0.32 and the part of the period it falls in
    assign w_ph_wide  = ({32'd0, r_acc} >> PH_DOWN) << PH_UP;
    assign w_ph32     = w_ph_wide[31:0];
    assign w_fall_end = {({1'b0, r_rl} + {1'b0, r_fl}), 16'd0};
    assign w_in_rise  = (w_ph32 < {r_rl, 16'd0});
    assign w_in_fall  = ({1'b0, w_ph32} < w_fall_end);

    // Shape derivation
    assign w_rise_q   = w_quot[15:0];
    always_comb begin
        w_fl_n = (w_oq > w_rise_q) ? (w_oq - w_rise_q) : 16'd0;
        if (w_fl_n == 16'd0) begin
            w_fl_n = 16'd1;
        end
    end
    assign w_mean_sum = {3'd0, r_rl, 15'd0} + {2'd0, r_prod[31:0]} + 34'd32768;

    // Cosine index
    assign w_u        = w_quot[16:0];
    assign w_mirror   = 18'd131072 - {1'b0, w_u};
    always_comb begin
        case (r_region)
            RGN_RISE: w_f = (w_u <= 17'd65536) ? w_u : w_mirror[16:0];
            RGN_FALL: w_f = w_u;
            default:  w_f = 17'd0;
        endcase
    end
    assign w_idx_full = ((CB+17)'(w_f) << CB) + (CB+17)'(32768);

    // Rounding of products
    assign w_rnd16   = {1'b0, r_prod} + 35'd32768;
    assign w_rnd14   = {1'b0, r_prod} + 35'd8192;
    assign w_a17     = w_rnd16[32:16];
    assign w_c       = w_rnd14[34:14];
    assign w_rnd_dev = r_prod[31:0] + 32'd16384;
    assign w_dev_mag = w_rnd_dev[31:15];
    assign w_pabs    = r_pdev[15] ? ({1'b0, ~r_pdev} + 17'd1) : {1'b0, r_pdev};
    assign w_labs    = r_ldev[15] ? ({1'b0, ~r_ldev} + 17'd1) : {1'b0, r_ldev};

    // Phase advance
    assign w_ps_c = (r_ps < 17'd32768) ? 17'd32768 : r_ps;
    assign w_inc  = (IW'(w_quot[33:0]) << PH_DOWN) >> PH_UP;
    assign w_sum  = (IW+1)'(r_acc) + {1'b0, w_inc};
    assign w_wrap = |w_sum[IW:PHASE_BITS];

    assign o_status.div_busy = w_div_busy;
    assign o_status.wrap_now = w_wrap;

    // Shared multiplier operand select
    always_comb begin
        case (i_cmd.op)
            OP_MUL_SHAPE: begin w_ma = {1'b0, w_oq};  w_mb = {1'b0, w_sq};  end
            OP_MUL_MEAN:  begin w_ma = {1'b0, r_fl};  w_mb = 17'd41722;     end
            OP_MUL_A:     begin w_ma = r_open;        w_mb = r_amp;         end
            OP_MUL_B:     begin w_ma = w_a17;         w_mb = {1'b0, r_fl};  end
            OP_MUL_C:     begin w_ma = w_a17;         w_mb = {1'b0, w_fs};  end
            OP_MUL_JIT:   begin w_ma = {1'b0, w_jd};  w_mb = w_pabs;        end
            OP_MUL_SHIM:  begin w_ma = {1'b0, w_sd};  w_mb = w_labs;        end
            default:      begin w_ma = 17'd0;         w_mb = 17'd0;         end
        endcase
    end

    // Divider operand select
    always_comb begin
        w_div_start = 1'b1;
        case (i_cmd.op)
            OP_DIV_RISE: begin
                w_div_nbits = DIV_BITS_SHAPE;
                w_div_num   = {16'd0, r_prod[31:0]} + {32'd0, w_den_shape[16:1]};
                w_div_den   = w_den_shape;
            end
            OP_DIV_PHASE: begin
                w_div_nbits = DIV_BITS_PHASE;
                if (w_in_rise) begin
                    w_div_num = {15'd0, w_ph32, 1'b0};
                    w_div_den = {1'b0, r_rl};
                end else begin
                    w_div_num = {16'd0, w_ph32 - {r_rl, 16'd0}};
                    w_div_den = {1'b0, r_fl};
                end
            end
            OP_DIV_OPEN: begin
                w_div_nbits = DIV_BITS_OPEN;
                w_div_num   = {19'd0, r_open, 12'd0} + {33'd0, r_mf[15:1]};
                w_div_den   = {1'b0, r_mf};
            end
            OP_DIV_INC: begin
                w_div_nbits = DIV_BITS_INC;
                w_div_num   = {r_phase_step, 16'd0};
                w_div_den   = w_ps_c;
            end
            default: begin
                w_div_start = 1'b0;
                w_div_nbits = '0;
                w_div_num   = '0;
                w_div_den   = '0;
            end
        endcase
    end

    gpo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_nbits (w_div_nbits),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // Quarter-wave cosine ROM, filled at elaboration
    for (genvar gi = 0; gi < COS_N; gi++) begin : g_cos
        assign w_cos_rom[gi] = qcos_entry(gi, CB);
    end

    // Configuration and the state that reset defines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= 32'd0;
            r_oq         <= 16'd32768;
            r_sq         <= 16'd512;
            r_fs         <= 16'd8192;
            r_jd         <= 16'd0;
            r_sd         <= 16'd0;
            r_acc        <= '0;
            r_ps         <= 17'd65536;
            r_amp        <= 17'd65536;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PHASE_STEP:      r_phase_step <= i_cfg_wdata;
                    CFG_OPEN_QUOTIENT:   r_oq <= i_cfg_wdata[15:0];
                    CFG_SPEED_QUOTIENT:  r_sq <= i_cfg_wdata[15:0];
                    CFG_FREQUENCY_SCALE: r_fs <= i_cfg_wdata[15:0];
                    CFG_JITTER_DEPTH:    r_jd <= i_cfg_wdata[15:0];
                    CFG_SHIMMER_DEPTH:   r_sd <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            case (i_cmd.op)
                OP_ADV_PHASE: r_acc <= w_sum[PHASE_BITS-1:0];
                OP_MUL_SHIM:  r_ps  <= r_pdev[15] ? (17'd65536 - w_dev_mag)
                                                   : (17'd65536 + w_dev_mag);
                OP_SET_SHIM:  r_amp <= r_ldev[15] ? (17'd65536 - w_dev_mag)
                                                   : (17'd65536 + w_dev_mag);
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD_IN: begin
                r_pdev <= i_in_data[15:0];
                r_ldev <= i_in_data[31:16];
            end
            OP_SET_RISE: begin
                r_rl <= w_rise_q;
                r_fl <= w_fl_n;
            end
            OP_SET_MEAN: r_mf <= (w_mean_sum[31:16] == 16'd0) ? 16'd1 : w_mean_sum[31:16];
            OP_DIV_PHASE: begin
                r_region <= w_in_rise ? RGN_RISE : (w_in_fall ? RGN_FALL : RGN_CLOSED);
            end
            OP_SET_IDX: begin
                r_idx  <= w_idx_full[CB+16:16];
                r_fold <= (w_u > 17'd65536);
            end
            OP_READ_COS: r_cos <= w_cos_rom[r_idx];
            OP_SET_OPEN: begin
                case (r_region)
                    RGN_RISE: r_open <= r_fold ? (17'd32768 + {1'b0, r_cos})
                                               : (17'd32768 - {1'b0, r_cos});
                    RGN_FALL: r_open <= {r_cos, 1'b0};
                    default:  r_open <= 17'd0;
                endcase
            end
            OP_MUL_A: r_openness <= (|w_quot[DIV_NW-1:16]) ? 16'hFFFF : w_quot[15:0];
            OP_SET_FLOW: r_flow <= (w_c > 21'd524287) ? 20'h7FFFF : w_c[19:0];
            OP_ADV_PHASE: r_wrap <= w_wrap;
            OP_OUT_LOAD: r_out <= {3'd0, r_wrap, r_openness, r_flow};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.op == OP_MUL_SHAPE) || (i_cmd.op == OP_MUL_MEAN) ||
            (i_cmd.op == OP_MUL_A) || (i_cmd.op == OP_MUL_B) ||
            (i_cmd.op == OP_MUL_C) || (i_cmd.op == OP_MUL_JIT) ||
            (i_cmd.op == OP_MUL_SHIM)) begin
            r_prod <= w_ma * w_mb;
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== src/gpo_ctrl.sv =====
// ----------------------------------------------------------------------------
// Glottal pulse oscillator controller
// Sequences one item through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module gpo_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  gpo_pkg::t_status  i_status,
    output gpo_pkg::t_cmd     o_cmd
);
    import gpo_pkg::*;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_MUL_SHAPE = 5'd1;
    localparam logic [4:0] S_DIV_RISE  = 5'd2;
    localparam logic [4:0] S_SET_RISE  = 5'd3;
    localparam logic [4:0] S_MUL_MEAN  = 5'd4;
    localparam logic [4:0] S_SET_MEAN  = 5'd5;
    localparam logic [4:0] S_DIV_PHASE = 5'd6;
    localparam logic [4:0] S_SET_IDX   = 5'd7;
    localparam logic [4:0] S_READ_COS  = 5'd8;
    localparam logic [4:0] S_SET_OPEN  = 5'd9;
    localparam logic [4:0] S_DIV_OPEN  = 5'd10;
    localparam logic [4:0] S_MUL_A     = 5'd11;
    localparam logic [4:0] S_MUL_B     = 5'd12;
    localparam logic [4:0] S_MUL_C     = 5'd13;
    localparam logic [4:0] S_SET_FLOW  = 5'd14;
    localparam logic [4:0] S_DIV_INC   = 5'd15;
    localparam logic [4:0] S_ADV_PHASE = 5'd16;
    localparam logic [4:0] S_MUL_JIT   = 5'd17;
    localparam logic [4:0] S_MUL_SHIM  = 5'd18;
    localparam logic [4:0] S_SET_SHIM  = 5'd19;
    localparam logic [4:0] S_OUT       = 5'd20;

    logic [4:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_op        w_op;

    always_comb begin
        n_state = r_state;
        w_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_op    = OP_LOAD_IN;
                    n_state = S_MUL_SHAPE;
                end
            end
            S_MUL_SHAPE: begin w_op = OP_MUL_SHAPE; n_state = S_DIV_RISE;  end
            S_DIV_RISE:  begin w_op = OP_DIV_RISE;  n_state = S_SET_RISE;  end
            S_SET_RISE: begin
                if (!i_status.div_busy) begin
                    w_op    = OP_SET_RISE;
                    n_state = S_MUL_MEAN;
                end
            end
            S_MUL_MEAN:  begin w_op = OP_MUL_MEAN;  n_state = S_SET_MEAN;  end
            S_SET_MEAN:  begin w_op = OP_SET_MEAN;  n_state = S_DIV_PHASE; end
            S_DIV_PHASE: begin w_op = OP_DIV_PHASE; n_state = S_SET_IDX;   end
            S_SET_IDX: begin
                if (!i_status.div_busy) begin
                    w_op    = OP_SET_IDX;
                    n_state = S_READ_COS;
                end
            end
            S_READ_COS:  begin w_op = OP_READ_COS;  n_state = S_SET_OPEN;  end
            S_SET_OPEN:  begin w_op = OP_SET_OPEN;  n_state = S_DIV_OPEN;  end
            S_DIV_OPEN:  begin w_op = OP_DIV_OPEN;  n_state = S_MUL_A;     end
            S_MUL_A: begin
                if (!i_status.div_busy) begin
                    w_op    = OP_MUL_A;
                    n_state = S_MUL_B;
                end
            end
            S_MUL_B:     begin w_op = OP_MUL_B;     n_state = S_MUL_C;     end
            S_MUL_C:     begin w_op = OP_MUL_C;     n_state = S_SET_FLOW;  end
            S_SET_FLOW:  begin w_op = OP_SET_FLOW;  n_state = S_DIV_INC;   end
            S_DIV_INC:   begin w_op = OP_DIV_INC;   n_state = S_ADV_PHASE; end
            S_ADV_PHASE: begin
                if (!i_status.div_busy) begin
                    w_op    = OP_ADV_PHASE;
                    n_state = i_status.wrap_now ? S_MUL_JIT : S_OUT;
                end
            end
            S_MUL_JIT:   begin w_op = OP_MUL_JIT;   n_state = S_MUL_SHIM;  end
            S_MUL_SHIM:  begin w_op = OP_MUL_SHIM;  n_state = S_SET_SHIM;  end
            S_SET_SHIM:  begin w_op = OP_SET_SHIM;  n_state = S_OUT;       end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_op    = OP_OUT_LOAD;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (w_op == OP_OUT_LOAD) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.op    = w_op;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Glottal pulse oscillator testbench
// Drives random and directed deviation items through the oscillator under a
// series of register settings, predicts every flow sample, openness and wrap
// flag in a local model and compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gpo_pkg::*;

    // Scoreboard: keeps its own copy of the oscillator state and settings,
    // predicts one result per accepted item and checks results in order.
    class flow_scoreboard;
        logic [31:0] step_reg;
        logic [15:0] oq_reg, sq_reg, fs_reg, jd_reg, sd_reg;
        logic [31:0] phase;
        logic [16:0] pscale, amp;
        logic [63:0] rise_len, fall_len, mean_len;
        logic [39:0] pending[$];
        int errors;

        function void reset_state();
            step_reg = 0; oq_reg = 16'd32768; sq_reg = 16'd512; fs_reg = 16'd8192;
            jd_reg = 0; sd_reg = 0; phase = 0; pscale = 17'd65536; amp = 17'd65536;
            errors = 0;
            derive();
        endfunction

        function void derive();
            logic [63:0] oq, sq, den, r, f, m;
            oq = oq_reg < 16384 ? 16384 : (oq_reg > 55706 ? 55706 : oq_reg);
            sq = sq_reg < 256 ? 256 : sq_reg;
            den = 256 + sq;
            r = (oq * sq + den / 2) / den;
            f = oq > r ? oq - r : 0;
            if (f < 1) f = 1;
            m = (r * 32768 + f * 41722 + 32768) >> 16;
            if (m < 1) m = 1;
            rise_len = r & 16'hFFFF; fall_len = f & 16'hFFFF; mean_len = m & 16'hFFFF;
        endfunction

        function void write_reg(logic [CFG_AW-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_PHASE_STEP:      step_reg = val;
                CFG_OPEN_QUOTIENT:   begin oq_reg = val[15:0]; derive(); end
                CFG_SPEED_QUOTIENT:  begin sq_reg = val[15:0]; derive(); end
                CFG_FREQUENCY_SCALE: fs_reg = val[15:0];
                CFG_JITTER_DEPTH:    jd_reg = val[15:0];
                CFG_SHIMMER_DEPTH:   sd_reg = val[15:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] cos_q15(logic [63:0] f);
            logic [63:0] x, x2, t, idx;
            longint s;
            if (f > 65536) f = 65536;
            idx = ((f << GPO_COS_TABLE_BITS) + 32768) >> 16;
            x = (idx * 64'd1686629713 + ((64'd1 << GPO_COS_TABLE_BITS) >> 1))
                >> GPO_COS_TABLE_BITS;
            x2 = (x * x + (64'd1 << 29)) >> 30;
            t = 64'd1 << 30;
            s = longint'(t);
            for (int k = 1; k <= 7; k++) begin
                t = ((t * x2) >> 30) / ((2 * k - 1) * (2 * k));
                if (k % 2) s -= longint'(t); else s += longint'(t);
            end
            if (s < 0) s = 0;
            if (s > (longint'(1) << 30)) s = longint'(1) << 30;
            return (64'(s) + (64'd1 << 14)) >> 15;
        endfunction

        function longint dev_scale(logic [63:0] depth, logic signed [15:0] dev);
            longint p;
            p = longint'(depth) * longint'(dev);
            if (p >= 0) return (p + 16384) >>> 15;
            return -((-p + 16384) >>> 15);
        endfunction

        // Predict the result of one accepted item and queue it.
        function void note_item(logic [15:0] pdev, logic [15:0] ldev);
            logic [63:0] ph, rl, fl, mf, opening, openness, a, b, c, flow, fsc;
            logic [63:0] ps, inc, sum, u, v;
            logic wrapped;
            ph = phase; rl = rise_len;
            fl = fall_len ? fall_len : 1; mf = mean_len ? mean_len : 1;
            opening = 0;
            if (ph < (rl << 16)) begin
                u = (ph << 1) / rl;
                if (u <= 65536) opening = 32768 - cos_q15(u);
                else opening = 32768 + cos_q15(131072 - u);
            end else if (ph < ((rl + fl) << 16)) begin
                v = (ph - (rl << 16)) / fl;
                opening = cos_q15(v) << 1;
            end
            openness = ((opening << 12) + mf / 2) / mf;
            if (openness > 65535) openness = 65535;
            fsc = fs_reg < 2048 ? 2048 : (fs_reg > 32768 ? 32768 : fs_reg);
            a = (opening * amp + 32768) >> 16;
            b = (a * fl + 32768) >> 16;
            c = (b * fsc + 8192) >> 14;
            flow = c > 524287 ? 524287 : c;
            ps = pscale < 32768 ? 32768 : pscale;
            inc = (64'(step_reg) << 16) / ps;
            sum = 64'(phase) + inc;
            wrapped = sum > 64'hFFFF_FFFF;
            phase = sum[31:0];
            if (wrapped) begin
                pscale = 17'(65536 + dev_scale(jd_reg > 32768 ? 32768 : jd_reg, pdev));
                amp = 17'(65536 + dev_scale(sd_reg > 58982 ? 58982 : sd_reg, ldev));
            end
            pending.push_back({3'b000, wrapped, openness[15:0], flow[19:0]});
        endfunction

        function void check_result(logic [39:0] got);
            logic [39:0] exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got[19:0] !== exp_r[19:0]) begin
                $display("%0t: flow_sample expected %h actual %h",
                         $realtime, exp_r[19:0], got[19:0]);
                errors++;
            end
            if (got[35:20] !== exp_r[35:20]) begin
                $display("%0t: fold_openness expected %h actual %h",
                         $realtime, exp_r[35:20], got[35:20]);
                errors++;
            end
            if (got[39:36] !== exp_r[39:36]) begin
                $display("%0t: period_wrapped expected %h actual %h",
                         $realtime, exp_r[39:36], got[39:36]);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_DW-1:0] i_cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;   // [15:0] period_deviation, [31:16] level_deviation
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;        // [19:0] flow, [35:20] openness, [36] wrapped

    flow_scoreboard board = new();
    int send_idle_pct = 0;   // percent of cycles the sender holds off
    int recv_idle_pct = 0;   // percent of cycles the receiver holds off
    int hold_off_cycles = 0; // one long receiver stall when nonzero

    glottal_pulse_oscillator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random ready, with an optional long hold-off counted here.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Check every result at the edge where it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end

    // Offer one item, with random idle cycles in front, and hold it until taken.
    task automatic send_item(logic [15:0] pdev, logic [15:0] ldev);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {ldev, pdev};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_item(pdev, ldev);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Let every expected result drain, then a margin for the block to settle.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] val);
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_wdata = val;
        board.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_settings();
        int sel;
        sel = $urandom_range(3);
        write_reg(CFG_PHASE_STEP, sel == 0 ? $urandom : $urandom_range(200000000, 5000000));
        write_reg(CFG_OPEN_QUOTIENT, sel == 1 ? $urandom_range(65535) :
                  $urandom_range(55706, 16384));
        write_reg(CFG_SPEED_QUOTIENT, $urandom_range(65535));
        write_reg(CFG_FREQUENCY_SCALE, sel == 2 ? $urandom_range(65535) :
                  $urandom_range(32768, 2048));
        write_reg(CFG_JITTER_DEPTH, $urandom_range(65535));
        write_reg(CFG_SHIMMER_DEPTH, $urandom_range(65535));
    endtask

    initial begin
        board.reset_state();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset settings, then extremes of every register.
        send_item(16'h0000, 16'h0000);
        drain();
        write_reg(CFG_PHASE_STEP, 32'h8000_0000);
        write_reg(CFG_JITTER_DEPTH, 32'h0000_8000);
        write_reg(CFG_SHIMMER_DEPTH, 32'h0000_E666);
        send_item(16'h8000, 16'h8000);
        send_item(16'h7FFF, 16'h7FFF);
        send_item(16'hFFFF, 16'h0001);
        send_item(16'h0001, 16'hFFFF);
        drain();
        // Out-of-range values are clamped on use; a huge step wraps many times.
        write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(CFG_OPEN_QUOTIENT, 32'h0000_0000);
        write_reg(CFG_SPEED_QUOTIENT, 32'h0000_0000);
        write_reg(CFG_FREQUENCY_SCALE, 32'h0000_0000);
        write_reg(CFG_JITTER_DEPTH, 32'h0000_FFFF);
        write_reg(CFG_SHIMMER_DEPTH, 32'h0000_FFFF);
        repeat (4) send_item(16'h8000, 16'h7FFF);
        drain();
        write_reg(CFG_PHASE_STEP, 32'd40_000_000);
        write_reg(CFG_OPEN_QUOTIENT, 32'h0000_FFFF);
        write_reg(CFG_SPEED_QUOTIENT, 32'h0000_FFFF);
        write_reg(CFG_FREQUENCY_SCALE, 32'h0000_FFFF);
        repeat (6) send_item(16'h7FFF, 16'h8000);
        drain();
        write_reg(CFG_PHASE_STEP, 32'd0);
        write_reg(CFG_OPEN_QUOTIENT, 32'd16384);
        write_reg(CFG_SPEED_QUOTIENT, 32'd256);
        write_reg(CFG_FREQUENCY_SCALE, 32'd32768);
        repeat (2) send_item(16'h1234, 16'hEDCB);
        drain();

        // Random phases with the idle patterns; a setting change per block.
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = p == 0 ? 21 : (p == 1 ? 53 : 0);
            recv_idle_pct = p == 0 ? 53 : (p == 1 ? 21 : 0);
            for (int blk = 0; blk < 6; blk++) begin
                random_settings();
                if (p == 2 && blk == 0) hold_off_cycles = 1500;
                repeat (38) send_item(16'($urandom), 16'($urandom));
                drain();
            end
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        drain();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("** glottal_pulse_oscillator: PASSED **");
        end else begin
            $display("** glottal_pulse_oscillator: FAILED **");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("** glottal_pulse_oscillator: FAILED **");
        $finish;
    end
endmodule
